### design/srrt_pkg.sv
// ----------------------------------------------------------------------------
// srrt_pkg
// Shared types, constants and helpers for the sorted range region table.
// ----------------------------------------------------------------------------
package srrt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 48;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
  localparam int OBJ_W       = 16;
  localparam int MODE_W      = 5;

  // Request kinds.
  localparam logic [1:0] REQ_MAP    = 2'd0;
  localparam logic [1:0] REQ_UNMAP  = 2'd1;
  localparam logic [1:0] REQ_PROT   = 2'd2;
  localparam logic [1:0] REQ_LOOKUP = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NORANGE = 3'd4;
  localparam logic [2:0] ST_RIGHTS  = 3'd5;

  // One stored range: [lo, hi) with its backing object and mode bits.
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [OBJ_W-1:0]  obj;
    logic [ADDR_W-1:0] off;
    logic [MODE_W-1:0] mode;
  } entry_t;

  // One accepted request.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] length;
    logic [OBJ_W-1:0]  region_object;
    logic [ADDR_W-1:0] object_offset;
    logic [2:0]        access_rights;
    logic [1:0]        inherit_mode;
    logic              write_access;
  } req_t;

  // One result.
  typedef struct packed {
    logic [2:0]        status;
    logic [OBJ_W-1:0]  hit_object;
    logic [ADDR_W-1:0] hit_offset;
    logic [CNT_W-1:0]  affected_count;
    logic [CNT_W-1:0]  entries_in_use;
  } res_t;

  // How one source entry turns into destination entries.
  typedef enum logic [3:0] {
    C_SKIP, C_COPY, C_DROP, C_UTRIML, C_UTRIMR, C_USPLIT, C_PFULL,
    C_PLEFT, C_PRIGHT, C_PMID, C_MINS, C_FULLSTOP
  } cls_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       setup;
    logic       proc;
    logic       wr;
    logic [1:0] piece;
    logic       adv;
    logic       fin;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       bad;
    logic       empty;
    logic       last;
    logic       out_busy;
    logic [1:0] pieces;
  } sts_t;

  // Number of destination entries written for one source entry.
  function automatic logic [1:0] cls_pieces(cls_e c);
    logic [1:0] p;
    case (c)
      C_SKIP, C_DROP:                         p = 2'd0;
      C_USPLIT, C_PLEFT, C_PRIGHT, C_MINS:    p = 2'd2;
      C_PMID:                                 p = 2'd3;
      default:                                p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

### design/srrt_ram.sv
// ----------------------------------------------------------------------------
// srrt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/srrt_ctrl.sv
// ----------------------------------------------------------------------------
// srrt_ctrl
// Sequencer: accepts a request, walks the table one entry at a time and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module srrt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  srrt_pkg::sts_t sts_i,
  output srrt_pkg::cmd_t cmd_o
);
  import srrt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_RD    = 7'b0000100,
    S_PROC  = 7'b0001000,
    S_EMIT1 = 7'b0010000,
    S_EMIT2 = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = (sts_i.bad || sts_i.empty) ? S_FIN : S_RD;
      end
      S_RD: begin
        state_d = S_PROC;
      end
      S_PROC: begin
        cmd_o.proc  = 1'b1;
        cmd_o.wr    = 1'b1;
        cmd_o.piece = 2'd0;
        if (sts_i.pieces >= 2'd2) begin
          state_d = S_EMIT1;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = sts_i.last ? S_FIN : S_RD;
        end
      end
      S_EMIT1: begin
        cmd_o.wr    = 1'b1;
        cmd_o.piece = 2'd1;
        if (sts_i.pieces == 2'd3) begin
          state_d = S_EMIT2;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = sts_i.last ? S_FIN : S_RD;
        end
      end
      S_EMIT2: begin
        cmd_o.wr    = 1'b1;
        cmd_o.piece = 2'd2;
        cmd_o.adv   = 1'b1;
        state_d     = sts_i.last ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/srrt_dp.sv
// ----------------------------------------------------------------------------
// srrt_dp
// Datapath: two table banks, scan counters, entry rewrite logic and the
// result register. Each pass reads the source bank and writes the rewritten
// table into the other bank; the banks swap when the pass commits.
// ----------------------------------------------------------------------------
module srrt_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srrt_pkg::req_t req_i,
  input  srrt_pkg::cmd_t cmd_i,
  output srrt_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output srrt_pkg::res_t res_o
);
  import srrt_pkg::*;

  localparam int ENT_W = $bits(entry_t);
  localparam logic [CNT_W:0] OCC_FULL1 = (CNT_W+1)'(TABLE_DEPTH);
  localparam logic [CNT_W:0] OCC_FULL2 = (CNT_W+1)'(TABLE_DEPTH - 1);

  // Control state.
  logic             bank_q;
  logic [CNT_W-1:0] n_q;
  logic             out_valid_q;

  // Per-request working registers.
  req_t              r_q;
  logic [ADDR_W-1:0] e_q;
  logic [CNT_W-1:0]  rd_idx_q, wr_idx_q;
  logic [2:0]        status_q;
  logic [CNT_W-1:0]  count_q;
  logic [OBJ_W-1:0]  hobj_q;
  logic [ADDR_W-1:0] hoff_q;
  logic              ovl_q, ins_done_q, stop_q, found_q;
  cls_e              cls_q;
  res_t              res_q;

  // Bank interface.
  logic [ENT_W-1:0] rdata0, rdata1;
  entry_t           ent, wd, new_ent;
  logic             we, we_any;

  // Request checks.
  logic [ADDR_W:0] sum;
  logic            bad;

  always_comb begin
    sum = {1'b0, r_q.addr} + {1'b0, r_q.length};
    bad = 1'b0;
    if (r_q.req_type != REQ_LOOKUP) begin
      bad = (r_q.length == '0) || sum[ADDR_W];
    end
    if (r_q.req_type == REQ_MAP) begin
      bad = bad || (|r_q.addr[PAGE_BITS-1:0]) || (|r_q.length[PAGE_BITS-1:0])
            || (|r_q.object_offset[PAGE_BITS-1:0]);
    end
  end

  // Entry classification.
  logic            touch, cov_l, cov_r, hit;
  logic [CNT_W:0]  occ;
  logic            full1, full2;
  logic [2:0]      nm;
  logic [ADDR_W-1:0] off_e, off_a;
  cls_e            cls_d, cls_use;
  logic [1:0]      pcs_use;
  logic [1:0]      need;

  always_comb begin
    ent     = bank_q ? entry_t'(rdata1) : entry_t'(rdata0);
    touch   = (ent.lo < e_q) && (ent.hi > r_q.addr);
    cov_l   = r_q.addr <= ent.lo;
    cov_r   = e_q >= ent.hi;
    hit     = (ent.lo <= r_q.addr) && (r_q.addr < ent.hi);
    occ     = {1'b0, wr_idx_q} + {1'b0, n_q} - {1'b0, rd_idx_q};
    full1   = occ >= OCC_FULL1;
    full2   = occ >= OCC_FULL2;
    nm      = r_q.access_rights;
    off_e   = ent.off + (e_q - ent.lo);
    off_a   = ent.off + (r_q.addr - ent.lo);
    need    = r_q.write_access ? 2'b10 : 2'b01;
    new_ent = '{lo: r_q.addr, hi: e_q, obj: r_q.region_object,
                off: r_q.object_offset, mode: {r_q.inherit_mode, r_q.access_rights}};
    cls_d   = C_SKIP;
    case (r_q.req_type)
      REQ_MAP: begin
        cls_d = (!ins_done_q && (ent.lo > r_q.addr)) ? C_MINS : C_COPY;
      end
      REQ_UNMAP: begin
        if (stop_q || !touch)   cls_d = C_COPY;
        else if (cov_l && cov_r) cls_d = C_DROP;
        else if (cov_l)          cls_d = C_UTRIML;
        else if (cov_r)          cls_d = C_UTRIMR;
        else                     cls_d = full1 ? C_FULLSTOP : C_USPLIT;
      end
      REQ_PROT: begin
        if (stop_q || !touch)   cls_d = C_COPY;
        else if (cov_l && cov_r) cls_d = C_PFULL;
        else if (cov_l)          cls_d = full1 ? C_FULLSTOP : C_PLEFT;
        else if (cov_r)          cls_d = full1 ? C_FULLSTOP : C_PRIGHT;
        else                     cls_d = full2 ? C_FULLSTOP : C_PMID;
      end
      default: cls_d = C_SKIP;
    endcase
    cls_use = cmd_i.proc ? cls_d : cls_q;
    pcs_use = cls_pieces(cls_use);
  end

  // Write data for the current piece.
  always_comb begin
    wd = ent;
    case (cls_use)
      C_UTRIML: begin
        wd.lo  = e_q;
        wd.off = off_e;
      end
      C_UTRIMR: wd.hi = r_q.addr;
      C_USPLIT: begin
        if (cmd_i.piece == 2'd0) begin
          wd.hi = r_q.addr;
        end else begin
          wd.lo  = e_q;
          wd.off = off_e;
        end
      end
      C_PFULL: wd.mode = {ent.mode[4:3], nm};
      C_PLEFT: begin
        if (cmd_i.piece == 2'd0) begin
          wd.hi   = e_q;
          wd.mode = {ent.mode[4:3], nm};
        end else begin
          wd.lo  = e_q;
          wd.off = off_e;
        end
      end
      C_PRIGHT: begin
        if (cmd_i.piece == 2'd0) begin
          wd.hi = r_q.addr;
        end else begin
          wd.lo   = r_q.addr;
          wd.off  = off_a;
          wd.mode = {ent.mode[4:3], nm};
        end
      end
      C_PMID: begin
        if (cmd_i.piece == 2'd0) begin
          wd.hi = r_q.addr;
        end else if (cmd_i.piece == 2'd1) begin
          wd.lo   = r_q.addr;
          wd.hi   = e_q;
          wd.off  = off_a;
          wd.mode = {ent.mode[4:3], nm};
        end else begin
          wd.lo  = e_q;
          wd.off = off_e;
        end
      end
      C_MINS: begin
        if (cmd_i.piece == 2'd0) begin
          wd = new_ent;
        end
      end
      default: wd = ent;
    endcase
    if (cmd_i.fin) begin
      wd = new_ent;
    end
    // The map append at the end only writes if no earlier entry took it.
    we_any = (cmd_i.wr && (pcs_use > cmd_i.piece))
             || (cmd_i.fin && (r_q.req_type == REQ_MAP) && (status_q == ST_OK)
                 && !ins_done_q);
    we     = we_any && !wr_idx_q[IDX_W];
  end

  // Two banks: read the source, write the other.
  srrt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && bank_q),
    .waddr_i (wr_idx_q[IDX_W-1:0]),
    .wdata_i (ENT_W'(wd)),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata0)
  );

  srrt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && !bank_q),
    .waddr_i (wr_idx_q[IDX_W-1:0]),
    .wdata_i (ENT_W'(wd)),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata1)
  );

  // Commit of a finished request.
  logic [2:0]       fin_status;
  logic             swap;
  logic [CNT_W-1:0] n_new;

  always_comb begin
    fin_status = status_q;
    swap       = 1'b0;
    n_new      = n_q;
    case (r_q.req_type)
      REQ_MAP: begin
        if (status_q == ST_OK) begin
          if (ovl_q) begin
            fin_status = ST_OVERLAP;
          end else if (n_q[IDX_W]) begin
            fin_status = ST_FULL;
          end else begin
            swap  = 1'b1;
            n_new = n_q + CNT_W'(1);
          end
        end
      end
      REQ_UNMAP, REQ_PROT: begin
        if (status_q != ST_BAD) begin
          swap  = 1'b1;
          n_new = wr_idx_q;
        end
      end
      default: swap = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        n_q         <= n_new;
        if (swap) begin
          bank_q <= !bank_q;
        end
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= req_i;
    end
    if (cmd_i.setup) begin
      e_q        <= sum[ADDR_W-1:0];
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      count_q    <= '0;
      hobj_q     <= '0;
      hoff_q     <= '0;
      ovl_q      <= 1'b0;
      ins_done_q <= 1'b0;
      stop_q     <= 1'b0;
      found_q    <= 1'b0;
      if (bad) begin
        status_q <= ST_BAD;
      end else if (r_q.req_type == REQ_LOOKUP) begin
        status_q <= ST_NORANGE;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (we_any) begin
      wr_idx_q <= wr_idx_q + CNT_W'(1);
    end
    if (cmd_i.adv) begin
      rd_idx_q <= rd_idx_q + CNT_W'(1);
    end
    if (cmd_i.proc) begin
      cls_q <= cls_d;
      if ((r_q.req_type == REQ_MAP) && touch) begin
        ovl_q <= 1'b1;
      end
      if (cls_d == C_MINS) begin
        ins_done_q <= 1'b1;
      end
      if (cls_d == C_FULLSTOP) begin
        stop_q   <= 1'b1;
        status_q <= ST_FULL;
      end
      case (cls_d)
        C_DROP, C_USPLIT, C_PFULL, C_PLEFT, C_PRIGHT, C_PMID:
          count_q <= count_q + CNT_W'(1);
        default: count_q <= count_q;
      endcase
      // Lookup keeps the first range that holds the address.
      if ((r_q.req_type == REQ_LOOKUP) && !found_q && hit) begin
        found_q <= 1'b1;
        if ((ent.mode[1:0] & need) == 2'b00) begin
          status_q <= ST_RIGHTS;
        end else begin
          status_q <= ST_OK;
          hobj_q   <= ent.obj;
          hoff_q   <= {off_a[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
        end
      end
    end
    if (cmd_i.fin) begin
      res_q.status         <= fin_status;
      res_q.hit_object     <= hobj_q;
      res_q.hit_offset     <= hoff_q;
      res_q.affected_count <= count_q;
      res_q.entries_in_use <= n_new;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o          = '0;
    sts_o.bad      = bad;
    sts_o.empty    = (n_q == '0);
    sts_o.last     = ((rd_idx_q + CNT_W'(1)) == n_q);
    sts_o.out_busy = out_valid_q && !out_ready_i;
    sts_o.pieces   = pcs_use;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### design/sorted_range_region_table.sv
// ----------------------------------------------------------------------------
// sorted_range_region_table
// Table of non-overlapping address ranges with map, unmap, protect, lookup.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one word per request, and each gives
// exactly one result word on the m_axis channel. Requests are worked one at
// a time: s_axis_tready_o is high only while no request is in progress.
// Each request walks the occupied part of the table once, reading one entry
// at a time, with a read state and a process state per entry and one extra
// write state for each additional piece that a split writes. The walk speed
// is set by the registered read of the table bank. A rejected request, or
// any request on an empty table, skips the walk and goes from setup straight
// to the finish state. The result sits in an output register; the next
// request is taken while it waits, and its own result is held back until the
// earlier word has been taken. Reset empties the table at once, with no
// clearing pass.
// ----------------------------------------------------------------------------
module sorted_range_region_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // addr, length, region_object, object_offset, access_rights, inherit_mode,
  // write_access, zero pad
  input  logic [167:0] s_axis_tdata_i,
  // req_type
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // hit_object, hit_offset, affected_count, entries_in_use, zero pad
  output logic [79:0]  m_axis_tdata_o,
  // status
  output logic [2:0]   m_axis_tuser_o
);
  import srrt_pkg::*;

  req_t req;
  res_t res;
  cmd_t cmd;
  sts_t sts;

  // Unpack the request word.
  always_comb begin
    req.req_type      = s_axis_tuser_i;
    req.addr          = s_axis_tdata_i[47:0];
    req.length        = s_axis_tdata_i[95:48];
    req.region_object = s_axis_tdata_i[111:96];
    req.object_offset = s_axis_tdata_i[159:112];
    req.access_rights = s_axis_tdata_i[162:160];
    req.inherit_mode  = s_axis_tdata_i[164:163];
    req.write_access  = s_axis_tdata_i[165];
  end

  srrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result word.
  assign m_axis_tuser_o = res.status;
  assign m_axis_tdata_o = {2'b00, res.entries_in_use, res.affected_count,
                           res.hit_offset, res.hit_object};

endmodule

### design/srrt_checker.sv
// ----------------------------------------------------------------------------
// srrt_checker
// Port-level checks for the sorted range region table.
// ----------------------------------------------------------------------------
module srrt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [79:0]  m_axis_tdata_o,
  input logic [2:0]   m_axis_tuser_o
);
  import srrt_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // One request at a time: no accept right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in progress");

  // Occupancy never passes the table depth.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[77:71] <= CNT_W'(TABLE_DEPTH))
    else $error("entries in use beyond table depth");

  // Hit fields are zero unless the request succeeded.
  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> m_axis_tdata_o[63:0] == '0)
    else $error("hit fields set on a failed request");

  // Only defined status codes appear.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= ST_RIGHTS)
    else $error("undefined status code");

endmodule

bind sorted_range_region_table srrt_checker u_srrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted range region table.
// ----------------------------------------------------------------------------
// A queue of requests is filled by a stimulus process: a short directed list,
// then random map, unmap, protect and lookup traffic mostly aimed at a narrow
// address window so that ranges overlap, split and fill the table. A driver
// feeds the slave channel at the falling edge. A monitor at the rising edge
// runs a behavioral copy of the table on each accepted request and compares
// every result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srrt_pkg::*;

  localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int          WATCHDOG = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [167:0] s_data = '0;
  logic [1:0]   s_user = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [79:0]  m_data;
  logic [2:0]   m_user;
  logic         s_fire = 1'b0;

  always #4 clk_i = ~clk_i;

  sorted_range_region_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  // Shadow copy of the range table.
  logic [47:0] sh_lo [TABLE_DEPTH];
  logic [47:0] sh_hi [TABLE_DEPTH];
  logic [47:0] sh_off[TABLE_DEPTH];
  logic [15:0] sh_obj[TABLE_DEPTH];
  logic [4:0]  sh_mode[TABLE_DEPTH];
  int          sh_used = 0;

  req_t pending_reqs[$];
  res_t expected_results[$];
  req_t cur_req;
  int   n_sent = 0;
  int   n_done = 0;
  int   n_errors = 0;
  int   n_full = 0;
  int   n_hits = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;

  function automatic void move_entry(int dst, int src);
    sh_lo[dst]   = sh_lo[src];
    sh_hi[dst]   = sh_hi[src];
    sh_off[dst]  = sh_off[src];
    sh_obj[dst]  = sh_obj[src];
    sh_mode[dst] = sh_mode[src];
  endfunction

  function automatic void open_entry(int k);
    for (int j = sh_used; j > k; j--) move_entry(j, j - 1);
    sh_used++;
  endfunction

  function automatic void close_entry(int k);
    for (int j = k; j + 1 < sh_used; j++) move_entry(j, j + 1);
    sh_used--;
  endfunction

  function automatic void set_entry(int k, logic [47:0] lo, logic [47:0] hi,
                                    logic [15:0] obj, logic [47:0] off,
                                    logic [4:0] mode);
    sh_lo[k]   = lo;
    sh_hi[k]   = hi;
    sh_obj[k]  = obj;
    sh_off[k]  = off;
    sh_mode[k] = mode;
  endfunction

  // Applies one request to the shadow table and returns its result word.
  function automatic res_t apply_request(req_t r);
    res_t        res;
    logic [63:0] end64;
    logic [47:0] a, e, lo, hi, off;
    logic [15:0] ob;
    logic [4:0]  md, nm;
    logic [1:0]  need;
    bit          ovf, hit;
    int          i, cnt;
    res = '0;
    cnt = 0;
    a = r.addr;
    end64 = {16'b0, r.addr} + {16'b0, r.length};
    e = end64[47:0];
    ovf = end64 > {16'b0, ADDR_MAX};
    res.status = ST_OK;
    case (r.req_type)
      REQ_MAP: begin
        if (r.length == 0 || a[11:0] != 0 || r.object_offset[11:0] != 0 ||
            r.length[11:0] != 0 || ovf) begin
          res.status = ST_BAD;
        end else begin
          for (i = 0; i < sh_used; i++)
            if (sh_lo[i] < e && sh_hi[i] > a) res.status = ST_OVERLAP;
          if (res.status == ST_OK && sh_used >= TABLE_DEPTH) res.status = ST_FULL;
          if (res.status == ST_OK) begin
            for (i = 0; i < sh_used; i++)
              if (sh_lo[i] > a) break;
            open_entry(i);
            set_entry(i, a, e, r.region_object, r.object_offset,
                      {r.inherit_mode, r.access_rights});
          end
        end
      end
      REQ_UNMAP, REQ_PROT: begin
        if (r.length == 0 || ovf) begin
          res.status = ST_BAD;
        end else begin
          i = 0;
          while (i < sh_used) begin
            lo = sh_lo[i];
            hi = sh_hi[i];
            off = sh_off[i];
            ob = sh_obj[i];
            md = sh_mode[i];
            nm = {md[4:3], r.access_rights};
            if (!(lo < e && hi > a)) begin
              i++;
              continue;
            end
            if (r.req_type == REQ_UNMAP) begin
              if (a <= lo && e >= hi) begin
                close_entry(i);
                cnt++;
              end else if (a <= lo) begin
                sh_off[i] = off + (e - lo);
                sh_lo[i] = e;
                i++;
              end else if (e >= hi) begin
                sh_hi[i] = a;
                i++;
              end else begin
                if (sh_used >= TABLE_DEPTH) begin
                  res.status = ST_FULL;
                  break;
                end
                open_entry(i + 1);
                set_entry(i + 1, e, hi, ob, off + (e - lo), md);
                sh_hi[i] = a;
                i += 2;
                cnt++;
              end
            end else begin
              if (a <= lo && e >= hi) begin
                sh_mode[i] = nm;
                i++;
              end else if (a <= lo) begin
                if (sh_used >= TABLE_DEPTH) begin
                  res.status = ST_FULL;
                  break;
                end
                open_entry(i + 1);
                set_entry(i + 1, e, hi, ob, off + (e - lo), md);
                sh_hi[i] = e;
                sh_mode[i] = nm;
                i += 2;
              end else if (e >= hi) begin
                if (sh_used >= TABLE_DEPTH) begin
                  res.status = ST_FULL;
                  break;
                end
                open_entry(i + 1);
                set_entry(i + 1, a, hi, ob, off + (a - lo), nm);
                sh_hi[i] = a;
                i += 2;
              end else begin
                if (sh_used + 2 > TABLE_DEPTH) begin
                  res.status = ST_FULL;
                  break;
                end
                open_entry(i + 1);
                open_entry(i + 2);
                set_entry(i + 1, a, e, ob, off + (a - lo), nm);
                set_entry(i + 2, e, hi, ob, off + (e - lo), md);
                sh_hi[i] = a;
                i += 3;
              end
              cnt++;
            end
          end
        end
      end
      default: begin
        res.status = ST_NORANGE;
        hit = 1'b0;
        for (i = 0; i < sh_used && !hit; i++) begin
          if (sh_lo[i] <= a && a < sh_hi[i]) begin
            hit = 1'b1;
            need = r.write_access ? 2'b10 : 2'b01;
            if ((sh_mode[i][1:0] & need) == 0) begin
              res.status = ST_RIGHTS;
            end else begin
              res.status = ST_OK;
              res.hit_object = sh_obj[i];
              res.hit_offset = ((a - sh_lo[i]) + sh_off[i]) & ~48'hFFF;
            end
          end
        end
      end
    endcase
    res.affected_count = cnt[6:0];
    res.entries_in_use = sh_used[6:0];
    return res;
  endfunction

  // Idling level per phase, chosen by how many requests have gone in.
  function automatic int sender_idle_pct();
    int ph;
    ph = (n_sent / 150) % 4;
    return (ph == 1) ? 58 : (ph == 3) ? 22 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    int ph;
    ph = (n_sent / 150) % 4;
    return (ph == 2) ? 58 : (ph == 3) ? 22 : 0;
  endfunction

  // Driver: presents requests and randomizes the receiver's ready.
  // A new word goes out only when the slot is empty or the last word was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || s_fire) begin
        if (pending_reqs.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct()) begin
          cur_req = pending_reqs.pop_front();
          s_data <= {2'b0, cur_req.write_access, cur_req.inherit_mode,
                     cur_req.access_rights, cur_req.object_offset,
                     cur_req.region_object, cur_req.length, cur_req.addr};
          s_user <= cur_req.req_type;
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // Monitor: predicts on each accepted request and checks each result word.
  always @(posedge clk_i) begin
    res_t exp_res, got;
    if (rst_ni) begin
      s_fire <= s_valid && s_ready;
      idle_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : idle_cycles + 1;
      if (s_valid && s_ready) begin
        exp_res = apply_request(cur_req);
        expected_results.push_back(exp_res);
        n_sent <= n_sent + 1;
        if (exp_res.status == ST_FULL) n_full <= n_full + 1;
        if (cur_req.req_type == REQ_LOOKUP && exp_res.status == ST_OK)
          n_hits <= n_hits + 1;
      end
      if (m_valid && m_ready) begin
        n_done <= n_done + 1;
        got.status = m_user;
        got.hit_object = m_data[15:0];
        got.hit_offset = m_data[63:16];
        got.affected_count = m_data[70:64];
        got.entries_in_use = m_data[77:71];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h status %0d", $time, m_data, m_user);
          n_errors <= n_errors + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (got !== exp_res) begin
            $display("%0t: result mismatch, expected st=%0d obj=%h off=%h cnt=%0d used=%0d",
                     $time, exp_res.status, exp_res.hit_object, exp_res.hit_offset,
                     exp_res.affected_count, exp_res.entries_in_use);
            $display("%0t:                  actual   st=%0d obj=%h off=%h cnt=%0d used=%0d",
                     $time, got.status, got.hit_object, got.hit_offset,
                     got.affected_count, got.entries_in_use);
            n_errors <= n_errors + 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no progress on either channel", $time);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [1:0] kind, logic [47:0] addr,
                                    logic [47:0] len, logic [2:0] rights);
    req_t r;
    r.req_type = kind;
    r.addr = addr;
    r.length = len;
    r.region_object = 16'($urandom);
    r.object_offset = {36'($urandom) << 4 | 36'($urandom_range(0, 15)), 12'h000};
    r.object_offset[47:44] = 4'($urandom);
    r.access_rights = rights;
    r.inherit_mode = 2'($urandom);
    r.write_access = 1'($urandom);
    return r;
  endfunction

  // Random request, mostly aimed at a small window of pages, sometimes near the top.
  function automatic req_t random_req(bit fill);
    req_t        r;
    logic [47:0] base, addr, len;
    int          pick;
    base = ($urandom_range(0, 9) == 0) ? ADDR_MAX - 48'(160 * 4096) + 1 : 48'h0;
    addr = base + 48'($urandom_range(0, 159)) * 48'h1000;
    len = 48'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 1) * 48'h1000;
    pick = fill ? 0 : $urandom_range(0, 99);
    if (pick < 36) begin
      r = make_req(REQ_MAP, addr, len, 3'($urandom));
    end else if (pick < 50) begin
      r = make_req(REQ_UNMAP, addr | 48'($urandom_range(0, 1) * $urandom_range(0, 4095)),
                   len, 3'($urandom));
    end else if (pick < 70) begin
      r = make_req(REQ_PROT, addr | 48'($urandom_range(0, 1) * $urandom_range(0, 4095)),
                   len + 48'($urandom_range(0, 1) * $urandom_range(0, 4095)),
                   3'($urandom));
    end else if (pick < 95) begin
      r = make_req(REQ_LOOKUP, addr | 48'($urandom_range(0, 4095)), len, 3'($urandom));
    end else begin
      r = make_req(2'($urandom), {16'($urandom), 32'($urandom)},
                   {16'($urandom), 32'($urandom)}, 3'($urandom));
      r.object_offset = {16'($urandom), 32'($urandom)};
    end
    return r;
  endfunction

  initial begin
    req_t r;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bad arguments, overlap, every split shape, lookup outcomes.
    pending_reqs.push_back(make_req(REQ_MAP, 48'h0001_0000, 48'h4000, 3'b111));
    pending_reqs.push_back(make_req(REQ_MAP, 48'h0002_0000, 48'h4000, 3'b001));
    pending_reqs.push_back(make_req(REQ_MAP, 48'h0000_0000, 48'h0000, 3'b111));
    pending_reqs.push_back(make_req(REQ_MAP, 48'h0003_0800, 48'h1000, 3'b111));
    pending_reqs.push_back(make_req(REQ_MAP, 48'h0003_0000, 48'h1800, 3'b111));
    r = make_req(REQ_MAP, 48'h0004_0000, 48'h1000, 3'b111);
    r.object_offset = 48'h0000_0000_0123;
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(REQ_MAP, ADDR_MAX - 48'hFFF, 48'h2000, 3'b111));
    pending_reqs.push_back(make_req(REQ_MAP, ADDR_MAX - 48'h1FFF, 48'h1000, 3'b111));
    pending_reqs.push_back(make_req(REQ_MAP, 48'h0001_2000, 48'h4000, 3'b111));
    pending_reqs.push_back(make_req(REQ_LOOKUP, 48'h0001_2345, 48'h0, 3'b0));
    r = make_req(REQ_LOOKUP, 48'h0002_0010, 48'h0, 3'b0);
    r.write_access = 1'b1;
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(REQ_LOOKUP, 48'h0009_0000, 48'h0, 3'b0));
    pending_reqs.push_back(make_req(REQ_PROT, 48'h0001_1000, 48'h1000, 3'b010));
    pending_reqs.push_back(make_req(REQ_PROT, 48'h0002_0000, 48'h1000, 3'b100));
    pending_reqs.push_back(make_req(REQ_PROT, 48'h0002_3000, 48'h3000, 3'b011));
    pending_reqs.push_back(make_req(REQ_PROT, 48'h0001_0000, 48'h0001_0000, 3'b111));
    pending_reqs.push_back(make_req(REQ_UNMAP, 48'h0001_1800, 48'h0800, 3'b0));
    pending_reqs.push_back(make_req(REQ_UNMAP, 48'h0002_0000, 48'h1000, 3'b0));
    pending_reqs.push_back(make_req(REQ_UNMAP, 48'h0001_3000, 48'h2000, 3'b0));
    pending_reqs.push_back(make_req(REQ_UNMAP, 48'h0050_0000, 48'h1000, 3'b0));
    pending_reqs.push_back(make_req(REQ_UNMAP, 48'h0, 48'h0, 3'b0));
    pending_reqs.push_back(make_req(REQ_PROT, ADDR_MAX, 48'h2, 3'b0));
    pending_reqs.push_back(make_req(REQ_UNMAP, 48'h0, ADDR_MAX, 3'b0));

    // Random traffic, with bursts of mostly single-page maps that fill the table.
    for (int n = 0; n < 1800; n++) begin
      pending_reqs.push_back(random_req((n % 400) >= 200 && (n % 400) < 280));
      if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 4);
    end
    // Let the last word go out, then wait for every result.
    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    wait (!s_valid && n_done == n_sent);
    repeat (300) @(posedge clk_i);

    $display("Ran %0d requests with %0d results; %0d lookup hits, %0d table-full answers.",
             n_sent, n_done, n_hits, n_full);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
